// ===== hw/rtl/phsvs_pkg.sv =====
package phsvs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT3_Q16     = 113512;
    localparam int RECIP3_Q11    = 683;
    localparam int Z_SAT         = 768;
    localparam int PIX_MAX       = 255;

    localparam logic [1:0] REG_HUE_COS   = 2'd0;
    localparam logic [1:0] REG_HUE_SIN   = 2'd1;
    localparam logic [1:0] REG_SAT_SHIFT = 2'd2;
    localparam logic [1:0] REG_VAL_SHIFT = 2'd3;

endpackage

// ===== hw/rtl/phsvs_div.sv =====
module phsvs_div import phsvs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [23:0]          i_rgb,
    input  logic [7:0]           i_diff,
    input  logic [7:0]           i_max,
    input  logic                 i_grey,
    output logic                 o_valid,
    output logic [23:0]          o_rgb,
    output logic [FRAC_BITS:0]   o_qs,
    output logic [FRAC_BITS:0]   o_qv,
    output logic                 o_grey
);

    localparam int QW  = FRAC_BITS + 1;
    localparam int RW  = FRAC_BITS + 9;
    localparam int PVW = FRAC_BITS + 17;
    localparam logic [RW-1:0] RCP_V =
        RW'(((64'd1 << (FRAC_BITS + 16)) / 64'd255) + 64'd1);

    logic          r_vld  [QW];
    logic [23:0]   r_rgb  [QW];
    logic [7:0]    r_max  [QW];
    logic          r_grey [QW];
    logic [7:0]    r_rem_s [QW];
    logic [QW-1:0] r_qs [QW];
    logic [QW-1:0] r_qv [QW];

    // value by reciprocal multiplication, max / 255 in Q1.F
    logic [PVW-1:0] v_prod;

    assign v_prod = PVW'(i_max) * PVW'(RCP_V);

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stg
        logic [8:0]    t_s;
        logic [8:0]    d_s;
        logic          b_s;
        logic          in_vld;
        logic [23:0]   in_rgb;
        logic [7:0]    in_max;
        logic          in_grey;
        logic [QW-1:0] in_qs;
        logic [QW-1:0] in_qv;

        if (k == 0) begin : g_first
            assign t_s     = {1'b0, i_diff};
            assign in_vld  = i_valid;
            assign in_rgb  = i_rgb;
            assign in_max  = i_max;
            assign in_grey = i_grey;
            assign in_qs   = '0;
            assign in_qv   = v_prod[PVW-1:16];
        end else begin : g_next
            assign t_s     = {r_rem_s[k-1], 1'b0};
            assign in_vld  = r_vld[k-1];
            assign in_rgb  = r_rgb[k-1];
            assign in_max  = r_max[k-1];
            assign in_grey = r_grey[k-1];
            assign in_qs   = r_qs[k-1];
            assign in_qv   = r_qv[k-1];
        end

        assign d_s = {1'b0, in_max};
        assign b_s = (t_s >= d_s);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rgb[k]   <= in_rgb;
                r_max[k]   <= in_max;
                r_grey[k]  <= in_grey;
                r_rem_s[k] <= b_s ? 8'(t_s - d_s) : t_s[7:0];
                r_qs[k]    <= {in_qs[QW-2:0], b_s};
                r_qv[k]    <= in_qv;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_rgb   = r_rgb[QW-1];
    assign o_qs    = r_qs[QW-1];
    assign o_qv    = r_qv[QW-1];
    assign o_grey  = r_grey[QW-1];

endmodule

// ===== hw/rtl/phsvs_mix.sv =====
module phsvs_mix import phsvs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [23:0]          i_rgb,
    input  logic [FRAC_BITS:0]   i_qs,
    input  logic [FRAC_BITS:0]   i_qv,
    input  logic                 i_grey,
    input  logic signed [15:0]   i_hue_cos,
    input  logic signed [15:0]   i_hue_sin,
    input  logic signed [16:0]   i_sat_shift,
    input  logic signed [16:0]   i_val_shift,
    output logic                 o_valid,
    output logic [23:0]          o_rgb
);

    localparam int F     = FRAC_BITS;
    localparam int QW    = F + 1;
    localparam int SHX   = (F > 16) ? F - 16 : 0;
    localparam int SHR   = (F < 16) ? 16 - F : 0;
    localparam int SHW   = 17 + SHX;
    localparam int SW    = ((QW + 1 > SHW) ? QW + 1 : SHW) + 1;
    localparam int CW    = F + 18;
    localparam int KW    = F + 19;
    localparam int PRW   = KW + 9;
    localparam int AW    = PRW + 2;
    localparam int XW    = AW - (F - 2);
    localparam int PDW   = XW + QW + 1;
    localparam int ZW    = PDW - 16 - F;
    localparam int NST   = 8;

    localparam logic signed [SW-1:0] ONE_S = {{(SW-QW){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [KW-1:0] ONE_K = KW'(1) <<< (F + 14);
    localparam logic signed [18:0]   SQ3   = 19'(SQRT3_Q16);
    localparam logic [9:0]           RCP3  = 10'(RECIP3_Q11);
    localparam logic signed [ZW-1:0] ZSAT  = ZW'(Z_SAT);

    logic [NST-1:0] r_vld;

    // stage 1: shifts and clamp
    logic signed [SHW-1:0] sh_s, sh_v;
    logic signed [SW-1:0]  sum_s, sum_v;
    logic [QW-1:0]         s_raw;
    logic [QW-1:0]         n1_s, n1_v;
    logic [QW-1:0]         r1_s, r1_v;
    logic [23:0]           r1_rgb;

    assign sh_s  = (SHW'(i_sat_shift) <<< SHX) >>> SHR;
    assign sh_v  = (SHW'(i_val_shift) <<< SHX) >>> SHR;
    assign s_raw = i_grey ? '0 : i_qs;
    assign sum_s = $signed({{(SW-QW){1'b0}}, s_raw}) + SW'(sh_s);
    assign sum_v = $signed({{(SW-QW){1'b0}}, i_qv}) + SW'(sh_v);

    always_comb begin
        if (sum_s < 0) begin
            n1_s = '0;
        end else if (sum_s > ONE_S) begin
            n1_s = ONE_S[QW-1:0];
        end else begin
            n1_s = sum_s[QW-1:0];
        end
        if (sum_v < 0) begin
            n1_v = '0;
        end else if (sum_v > ONE_S) begin
            n1_v = ONE_S[QW-1:0];
        end else begin
            n1_v = sum_v[QW-1:0];
        end
    end

    // stage 2: saturation times trig
    logic signed [CW-1:0] r2_c, r2_sn;
    logic [QW-1:0]        r2_v;
    logic [23:0]          r2_rgb;

    // stage 3: sqrt3 term
    logic signed [CW+18:0] m3_p;
    logic signed [CW-1:0]  r3_c, r3_r3;
    logic [QW-1:0]         r3_v;
    logic [23:0]           r3_rgb;

    assign m3_p = r2_sn * SQ3;

    // stage 4: matrix coefficients
    logic signed [KW-1:0] r4_dg, r4_pl, r4_mi;
    logic [QW-1:0]        r4_v;
    logic [23:0]          r4_rgb;

    // stage 5: products
    logic signed [8:0]     px [3];
    logic signed [PRW-1:0] r5_p [3][3];
    logic [QW-1:0]         r5_v;

    assign px[0] = $signed({1'b0, r4_rgb[7:0]});
    assign px[1] = $signed({1'b0, r4_rgb[15:8]});
    assign px[2] = $signed({1'b0, r4_rgb[23:16]});

    // stage 6: row sums
    logic signed [AW-1:0] acc [3];
    logic signed [XW-1:0] r6_x [3];
    logic [QW-1:0]        r6_v;

    // stage 7: scale by value
    logic signed [PDW-1:0] r7_y [3];

    // stage 8: divide by three and clamp
    logic signed [ZW-1:0] z [3];
    logic [19:0]          q3 [3];
    logic [7:0]           n8_ch [3];
    logic [7:0]           r8_ch [3];

    for (genvar j = 0; j < 3; j++) begin : g_ch
        assign acc[j] = AW'(r5_p[j][0]) + AW'(r5_p[j][1]) + AW'(r5_p[j][2]);
        assign z[j]   = r7_y[j][PDW-1:16+F];
        assign q3[j]  = z[j][9:0] * RCP3;
        always_comb begin
            if (z[j] < 0) begin
                n8_ch[j] = '0;
            end else if (z[j] >= ZSAT) begin
                n8_ch[j] = 8'(PIX_MAX);
            end else begin
                n8_ch[j] = q3[j][18:11];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s   <= n1_s;
            r1_v   <= n1_v;
            r1_rgb <= i_rgb;

            r2_c   <= $signed({1'b0, r1_s}) * i_hue_cos;
            r2_sn  <= $signed({1'b0, r1_s}) * i_hue_sin;
            r2_v   <= r1_v;
            r2_rgb <= r1_rgb;

            r3_c   <= r2_c;
            r3_r3  <= m3_p[CW+15:16];
            r3_v   <= r2_v;
            r3_rgb <= r2_rgb;

            r4_dg  <= ONE_K + (KW'(r3_c) <<< 1);
            r4_pl  <= ONE_K - KW'(r3_c) + KW'(r3_r3);
            r4_mi  <= ONE_K - KW'(r3_c) - KW'(r3_r3);
            r4_v   <= r3_v;
            r4_rgb <= r3_rgb;

            r5_p[0][0] <= r4_dg * px[0];
            r5_p[0][1] <= r4_mi * px[1];
            r5_p[0][2] <= r4_pl * px[2];
            r5_p[1][0] <= r4_pl * px[0];
            r5_p[1][1] <= r4_dg * px[1];
            r5_p[1][2] <= r4_mi * px[2];
            r5_p[2][0] <= r4_mi * px[0];
            r5_p[2][1] <= r4_pl * px[1];
            r5_p[2][2] <= r4_dg * px[2];
            r5_v       <= r4_v;

            for (int j = 0; j < 3; j++) begin
                r6_x[j]  <= acc[j][AW-1:F-2];
                r7_y[j]  <= r6_x[j] * $signed({1'b0, r6_v});
                r8_ch[j] <= n8_ch[j];
            end
            r6_v <= r5_v;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_rgb   = {r8_ch[2], r8_ch[1], r8_ch[0]};

endmodule

// ===== hw/rtl/pixel_hue_sat_value_shift_core.sv =====
// path: input stage, then the divider pipeline, then the mix pipeline to the output
// throughput: one pixel per cycle while the output is not stalled, with a one-bit-per-stage divider pipeline
// a stall on the output holds every stage; nothing is lost or repeated
// reset: synchronous, active low; clears valid bits and sets hue_cos to 1.0,
// hue_sin, sat_shift and val_shift to 0
module pixel_hue_sat_value_shift_core import phsvs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // in_red, in_green, in_blue
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_red, out_green, out_blue
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic signed [15:0] r_hue_cos, r_hue_sin;
    logic signed [16:0] r_sat_shift, r_val_shift;
    logic               wr;
    logic               en;

    assign o_pready = 1'b1;
    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_cos   <= 16'sd16384;
            r_hue_sin   <= '0;
            r_sat_shift <= '0;
            r_val_shift <= '0;
        end else if (wr) begin
            case (i_paddr[3:2])
                REG_HUE_COS:   r_hue_cos   <= i_pwdata[15:0];
                REG_HUE_SIN:   r_hue_sin   <= i_pwdata[15:0];
                REG_SAT_SHIFT: r_sat_shift <= i_pwdata[16:0];
                REG_VAL_SHIFT: r_val_shift <= i_pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_HUE_COS:   o_prdata = {16'd0, r_hue_cos};
            REG_HUE_SIN:   o_prdata = {16'd0, r_hue_sin};
            REG_SAT_SHIFT: o_prdata = {15'd0, r_sat_shift};
            REG_VAL_SHIFT: o_prdata = {15'd0, r_val_shift};
            default:       o_prdata = '0;
        endcase
    end

    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // input stage: max, min, range
    logic [7:0]  in_r, in_g, in_b, mx, mn;
    logic        r_a_vld;
    logic [23:0] r_a_rgb;
    logic [7:0]  r_a_max, r_a_diff;
    logic        r_a_grey;

    assign in_r = i_s_axis_tdata[7:0];
    assign in_g = i_s_axis_tdata[15:8];
    assign in_b = i_s_axis_tdata[23:16];

    always_comb begin
        mx = in_r;
        mn = in_r;
        if (in_g > mx) mx = in_g;
        if (in_b > mx) mx = in_b;
        if (in_g < mn) mn = in_g;
        if (in_b < mn) mn = in_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rgb  <= i_s_axis_tdata;
            r_a_max  <= mx;
            r_a_diff <= 8'(mx - mn);
            r_a_grey <= (mx == mn);
        end
    end

    logic               d_vld;
    logic [23:0]        d_rgb;
    logic [FRAC_BITS:0] d_qs, d_qv;
    logic               d_grey;

    phsvs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_vld),
        .i_rgb   (r_a_rgb),
        .i_diff  (r_a_diff),
        .i_max   (r_a_max),
        .i_grey  (r_a_grey),
        .o_valid (d_vld),
        .o_rgb   (d_rgb),
        .o_qs    (d_qs),
        .o_qv    (d_qv),
        .o_grey  (d_grey)
    );

    phsvs_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (d_vld),
        .i_rgb       (d_rgb),
        .i_qs        (d_qs),
        .i_qv        (d_qv),
        .i_grey      (d_grey),
        .i_hue_cos   (r_hue_cos),
        .i_hue_sin   (r_hue_sin),
        .i_sat_shift (r_sat_shift),
        .i_val_shift (r_val_shift),
        .o_valid     (o_m_axis_tvalid),
        .o_rgb       (o_m_axis_tdata)
    );

endmodule

// ===== tb/pixel_hue_sat_value_shift_core_chk.sv =====
module pixel_hue_sat_value_shift_core_chk import phsvs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_pixels_out
);
    localparam int F = FRAC_BITS_DEF;

    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic signed [16:0] sat_q;
    logic signed [16:0] val_q;
    logic [23:0] recolour_q[$];

    function automatic longint fdiv(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint unit_clamp(longint x);
        if (x < 0) return 0;
        if (x > (64'sd1 <<< F)) return 64'sd1 <<< F;
        return x;
    endfunction

    function automatic longint shift_to_f(logic signed [16:0] sh);
        longint s;
        s = sh;
        if (F >= 16) return s * (64'sd1 <<< (F - 16));
        return fdiv(s, 64'sd1 <<< (16 - F));
    endfunction

    function automatic logic [7:0] mix(longint a, longint b, longint c,
                                       longint r, longint g, longint bl, longint v);
        longint acc, x, y;
        acc = a * r + b * g + c * bl;
        x = fdiv(acc, 64'sd1 <<< (F - 2));
        y = fdiv(x * v, 64'sd3 <<< (16 + F));
        if (y < 0) return 8'd0;
        if (y > 255) return 8'd255;
        return y[7:0];
    endfunction

    function automatic logic [23:0] recolour(logic [23:0] px);
        longint r, g, b, mx, mn, v, s, c, sn, r3, dg, pl, mi, one_k;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        one_k = 64'sd1 <<< (F + 14);
        v = mx * (64'sd1 <<< F) / 255;
        s = (mx == mn || mx == 0) ? 0 : (mx - mn) * (64'sd1 <<< F) / mx;
        s = unit_clamp(s + shift_to_f(sat_q));
        v = unit_clamp(v + shift_to_f(val_q));
        c = s * longint'(cos_q);
        sn = s * longint'(sin_q);
        r3 = fdiv(sn * SQRT3_Q16, 65536);
        dg = one_k + 2 * c;
        pl = one_k - c + r3;
        mi = one_k - c - r3;
        return {mix(mi, pl, dg, r, g, b, v), mix(pl, dg, mi, r, g, b, v),
                mix(dg, mi, pl, r, g, b, v)};
    endfunction

    assign o_pending = recolour_q.size();

    always @(posedge i_clk) begin
        logic [23:0] want;
        int          bad;
        bad = 0;
        if (!i_rst_n) begin
            cos_q <= 16'sd16384;
            sin_q <= '0;
            sat_q <= '0;
            val_q <= '0;
            recolour_q.delete();
            o_errors <= 0;
            o_pixels_out <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_HUE_COS:   cos_q <= i_pwdata[15:0];
                    REG_HUE_SIN:   sin_q <= i_pwdata[15:0];
                    REG_SAT_SHIFT: sat_q <= i_pwdata[16:0];
                    REG_VAL_SHIFT: val_q <= i_pwdata[16:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                recolour_q.insert(recolour_q.size(), recolour(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                o_pixels_out <= o_pixels_out + 1;
                if (recolour_q.size() == 0) begin
                    $error("unexpected output transaction %h", i_m_tdata);
                    bad++;
                end else begin
                    want = recolour_q.pop_front();
                    if (want[7:0] !== i_m_tdata[7:0]) begin
                        $error("out_red exp %0d got %0d", want[7:0], i_m_tdata[7:0]);
                        bad++;
                    end
                    if (want[15:8] !== i_m_tdata[15:8]) begin
                        $error("out_green exp %0d got %0d", want[15:8], i_m_tdata[15:8]);
                        bad++;
                    end
                    if (want[23:16] !== i_m_tdata[23:16]) begin
                        $error("out_blue exp %0d got %0d", want[23:16], i_m_tdata[23:16]);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end
endmodule

// ===== tb/pixel_hue_sat_value_shift_core_tb.sv =====
module pixel_hue_sat_value_shift_core_tb import phsvs_pkg::*;;
    localparam int LATENCY = FRAC_BITS_DEF + 10;
    localparam int IDLE_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending, pixels_out;
    int          pixels_in = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    always #5 i_clk = ~i_clk;

    pixel_hue_sat_value_shift_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    pixel_hue_sat_value_shift_core_chk checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending), .o_pixels_out(pixels_out)
    );

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("FAIL pixel_hue_sat_value_shift_core");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_pixel(logic [23:0] px, bit gaps);
        int n;
        if (gaps && !calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge i_clk); while (!s_tready);
        pixels_in++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_all(logic [15:0] c, logic [15:0] s, logic [16:0] sat,
                           logic [16:0] val);
        reg_write(REG_HUE_COS, {$urandom} & 32'hFFFF0000 | c);
        reg_write(REG_HUE_SIN, {16'h0, s});
        reg_write(REG_SAT_SHIFT, {15'h0, sat});
        reg_write(REG_VAL_SHIFT, {15'h0, val});
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return {3{8'($urandom)}};
            1: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom), 8'($urandom)};
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [23:0] directed[$];
        int phase;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00,
                     24'hFF0000, 24'hFF00FF, 24'h01FE80, 24'h010000, 24'h7F7F80,
                     24'hAA5500, 24'h55AAFF};
        foreach (directed[i]) send_pixel(directed[i], 1'b0);
        drain();
        set_all(16'hC000, 16'h4000, 17'h0FFFF, 17'h10001);
        foreach (directed[i]) send_pixel(directed[i], 1'b1);
        drain();
        set_all(16'h7FFF, 16'h8000, 17'h10001, 17'h0FFFF);
        foreach (directed[i]) send_pixel(directed[i], 1'b1);
        drain();
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 5) calm = 1'b1;
            else set_all(16'($urandom_range(0, 32768) - 16384),
                         16'($urandom_range(0, 32768) - 16384),
                         17'($urandom), 17'($urandom));
            if (phase == 4) set_all(16'($urandom), 16'($urandom), 17'($urandom),
                                    17'($urandom));
            if (phase == 2) hold_off = 1'b1;
            repeat (100) send_pixel(rand_pixel(), 1'b1);
            drain();
        end
        set_all(16'd16384, 16'd0, 17'd0, 17'd0);
        repeat (20) send_pixel(rand_pixel(), 1'b0);
        drain();
        $display("sent %0d pixels, checked %0d recoloured pixels", pixels_in, pixels_out);
        $display("covered extreme and random trig and shift settings, stalls and a long hold-off");
        if (errors == 0 && pending == 0) begin
            $display("PASS pixel_hue_sat_value_shift_core");
        end else begin
            $display("FAIL pixel_hue_sat_value_shift_core");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/phsvs_pkg.sv
hw/rtl/phsvs_div.sv
hw/rtl/phsvs_mix.sv
hw/rtl/pixel_hue_sat_value_shift_core.sv
tb/pixel_hue_sat_value_shift_core_chk.sv
tb/pixel_hue_sat_value_shift_core_tb.sv
